[sv/oid_asd_pkg.sv]
// Shared types and constants for the object identifier arc stream decoder.
package oid_asd_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [7:0] ARC_LIMIT_RESET = 8'd128;

	// Status codes carried on the last result of an identifier.
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_TOO_MANY  = 2'd1;
	localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

	// Splitting the first byte: byte / 40 is (byte * 205) >> 13 for any 8-bit byte.
	localparam int unsigned FIRST_DIVISOR = 40;
	localparam logic [15:0] DIV40_RECIP = 16'd205;
	localparam int unsigned DIV40_SHIFT = 13;

	typedef struct packed {
		logic [7:0] content_byte;
		logic       final_byte;
	} oid_in_t;

	typedef struct packed {
		logic [31:0] arc_value;
		logic        arc_present;
		logic        end_of_oid;
		logic [1:0]  status;
	} oid_out_t;

	// One classified byte: up to two arcs, plus the end marking.
	typedef struct packed {
		logic [31:0] val_a;
		logic [5:0]  val_b;
		logic [1:0]  n_arcs;
		logic        fin;
		logic [1:0]  status;
	} oid_entry_t;

endpackage

[sv/oid_asd_front.sv]
// Front part: accepts content bytes, keeps the per-identifier state and classifies each byte.
module oid_asd_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  oid_asd_pkg::oid_in_t    in_data,
	input  logic                    cfg_we,
	input  logic [7:0]              cfg_data,
	input  logic                    q_full,
	output logic                    push,
	output oid_asd_pkg::oid_entry_t entry
);

	logic [31:0] acc_q;
	logic [7:0]  count_q;
	logic        first_q;
	logic        too_many_q;
	logic [7:0]  limit_q;

	logic        accept;
	logic        more;
	logic [15:0] prod;
	logic [2:0]  quot;
	logic [7:0]  rem_full;
	logic [8:0]  next1;
	logic [8:0]  next2;
	logic [7:0]  cnt1;
	logic [7:0]  cnt2;
	logic        tm1;
	logic        tm2;
	logic [31:0] acc_new;
	logic [31:0] acc_next;
	logic [7:0]  cnt_end;
	logic        tm_end;
	logic        first_next;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign more     = in_data.content_byte[7];

	assign prod     = {8'd0, in_data.content_byte} * oid_asd_pkg::DIV40_RECIP;
	assign quot     = prod[15:oid_asd_pkg::DIV40_SHIFT];
	assign rem_full = in_data.content_byte
		- ({5'd0, quot} * 8'(oid_asd_pkg::FIRST_DIVISOR));

	// Arc counting saturates at 255; each counted arc may trip the sticky limit flag.
	assign next1 = {1'b0, count_q} + 9'd1;
	assign tm1   = too_many_q || (next1 > {1'b0, limit_q});
	assign cnt1  = next1[8] ? 8'hFF : next1[7:0];
	assign next2 = {1'b0, cnt1} + 9'd1;
	assign tm2   = tm1 || (next2 > {1'b0, limit_q});
	assign cnt2  = next2[8] ? 8'hFF : next2[7:0];

	assign acc_new = {acc_q[24:0], in_data.content_byte[6:0]};

	always_comb begin
		entry      = '0;
		acc_next   = acc_q;
		cnt_end    = count_q;
		tm_end     = too_many_q;
		first_next = first_q;
		if (first_q) begin
			entry.n_arcs = {1'b0, !tm1} + {1'b0, !tm2};
			entry.val_a  = {29'd0, quot};
			entry.val_b  = rem_full[5:0];
			tm_end       = tm2;
			cnt_end      = cnt2;
			first_next   = 1'b0;
		end else begin
			acc_next = acc_new;
			if (!more) begin
				entry.n_arcs = {1'b0, !tm1};
				entry.val_a  = acc_new;
				tm_end       = tm1;
				cnt_end      = cnt1;
				acc_next     = '0;
			end
		end
		entry.fin = in_data.final_byte;
		if (tm_end) begin
			entry.status = oid_asd_pkg::STATUS_TOO_MANY;
		end else if (more) begin
			entry.status = oid_asd_pkg::STATUS_TRUNCATED;
		end else begin
			entry.status = oid_asd_pkg::STATUS_OK;
		end
	end

	assign push = accept && ((entry.n_arcs != 2'd0) || in_data.final_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			count_q    <= '0;
			first_q    <= 1'b1;
			too_many_q <= 1'b0;
			limit_q    <= oid_asd_pkg::ARC_LIMIT_RESET;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_data;
			end
			if (accept) begin
				if (in_data.final_byte) begin
					acc_q      <= '0;
					count_q    <= '0;
					first_q    <= 1'b1;
					too_many_q <= 1'b0;
				end else begin
					acc_q      <= acc_next;
					count_q    <= cnt_end;
					first_q    <= first_next;
					too_many_q <= tm_end;
				end
			end
		end
	end

endmodule

[sv/oid_asd_queue.sv]
// Short queue of classified entries between the front and back parts.
module oid_asd_queue #(
	parameter int unsigned DEPTH = oid_asd_pkg::QUEUE_DEPTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  oid_asd_pkg::oid_entry_t push_entry,
	input  logic                    pop,
	output oid_asd_pkg::oid_entry_t head,
	output logic                    full,
	output logic                    empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	oid_asd_pkg::oid_entry_t slots_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] fill_q;

	assign full  = (fill_q == CW'(DEPTH));
	assign empty = (fill_q == '0);
	assign head  = slots_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + CW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - CW'(1);
			end
		end
	end

endmodule

[sv/oid_asd_back.sv]
// Back part: turns each queued entry into one or two results through an output register.
module oid_asd_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  oid_asd_pkg::oid_entry_t head,
	input  logic                    empty,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_ready,
	output oid_asd_pkg::oid_out_t   out_data
);

	logic                  valid_q;
	oid_asd_pkg::oid_out_t data_q;
	logic                  second_q;
	logic                  load;
	logic                  is_last;
	oid_asd_pkg::oid_out_t res;

	assign load    = !empty && (!valid_q || out_ready);
	assign is_last = (head.n_arcs != 2'd2) || second_q;
	assign pop     = load && is_last;

	always_comb begin
		res = '0;
		if (head.n_arcs == 2'd0) begin
			res.end_of_oid = 1'b1;
			res.status     = head.status;
		end else begin
			res.arc_present = 1'b1;
			res.arc_value   = second_q ? {26'd0, head.val_b} : head.val_a;
			if (is_last && head.fin) begin
				res.end_of_oid = 1'b1;
				res.status     = head.status;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			second_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q  <= 1'b1;
				second_q <= !is_last;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

[sv/oid_arc_stream_decoder.sv]
// Top level of the streaming object identifier arc decoder.
// This block decodes the content bytes of ASN.1 object identifiers, one byte per input
// transaction, with final_byte marking the last byte of each identifier. The first byte
// of an identifier yields two arcs (byte divided by 40 and the remainder); later bytes
// are shifted seven bits at a time into a 32-bit accumulator that wraps, and an arc is
// produced when bit 7 of a byte is clear. Each arc is one output transaction. Arcs past
// the arc_limit register are dropped and the identifier ends with status "too many arcs";
// a final byte that still has bit 7 set ends with status "truncated". When the final byte
// produces no arc, a status-only transaction with arc_present low closes the identifier.
// Rate: the front part accepts one byte per clock whenever the entry queue has room, and
// the back part delivers one result per clock while out_ready is high. The first byte of
// an identifier carries up to two arcs, which leave the output register one after the
// other; the QUEUE_DEPTH-entry queue between the parts absorbs that burst. A stream thus
// sustains one byte per cycle while results do not outnumber bytes, that is, while each
// identifier has a non-final continuation byte after its head. Otherwise the output side
// sets the pace at one result per cycle and the queue fills and stalls the input. Bytes
// reach the output through the entry queue and the output register. There is no clearing
// pass after reset. arc_limit resets to 128 and is written through the always-ready cfg
// channel; the user writes it only while the block is idle, which nothing enforces.
module oid_arc_stream_decoder #(
	parameter int unsigned QUEUE_DEPTH = oid_asd_pkg::QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  oid_asd_pkg::oid_in_t  in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output oid_asd_pkg::oid_out_t out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [7:0]            cfg_data
);

	logic                    q_push;
	logic                    q_pop;
	logic                    q_full;
	logic                    q_empty;
	oid_asd_pkg::oid_entry_t q_in;
	oid_asd_pkg::oid_entry_t q_head;

	// The configuration register is a single flop bank, so a write never has to wait.
	assign cfg_ready = 1'b1;

	oid_asd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.q_full   (q_full),
		.push     (q_push),
		.entry    (q_in)
	);

	oid_asd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_in),
		.pop        (q_pop),
		.head       (q_head),
		.full       (q_full),
		.empty      (q_empty)
	);

	oid_asd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.empty     (q_empty),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// A nonzero status only ever appears on the closing transaction of an identifier.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_data.status != oid_asd_pkg::STATUS_OK)) |-> out_data.end_of_oid)
		else $error("nonzero status on a transaction that does not end the identifier");

	// A transaction without an arc is a status-only close and carries a zero value.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.arc_present)
			|-> (out_data.end_of_oid && (out_data.arc_value == '0)))
		else $error("status-only transaction is malformed");

	// The front must never write into a full queue.
	assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (!q_full || q_pop))
		else $error("entry pushed into a full queue");

	// A popped entry must exist.
	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("entry popped from an empty queue");

endmodule
